[src/c_subset_lexer_assert.svh]
// Assertion macros shared by the lexer RTL.
// Included by cslx_scan and cslx_obuf; needs a clock and an active-low reset.
`ifndef C_SUBSET_LEXER_ASSERT_SVH
`define C_SUBSET_LEXER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define CSLX_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define CSLX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/cslx_pkg.sv]
// Package for the C subset lexer: token kinds, scan modes, character classes.
// Used by cslx_scan, cslx_obuf and c_subset_lexer; no dependencies.
`default_nettype none

package cslx_pkg;

    localparam int POSITION_BITS_DEF    = 16;
    localparam int MAX_TOKEN_LENGTH_DEF = 255;
    localparam int TDATA_W              = 32;

    // Scan modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_IDENT  = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;

    // Token kinds
    localparam logic [4:0] KIND_UNKNOWN = 5'd0;
    localparam logic [4:0] KIND_LBRACE  = 5'd1;
    localparam logic [4:0] KIND_RBRACE  = 5'd2;
    localparam logic [4:0] KIND_LPAREN  = 5'd3;
    localparam logic [4:0] KIND_RPAREN  = 5'd4;
    localparam logic [4:0] KIND_SEMI    = 5'd5;
    localparam logic [4:0] KIND_MINUS   = 5'd6;
    localparam logic [4:0] KIND_TILDE   = 5'd7;
    localparam logic [4:0] KIND_BANG    = 5'd8;
    localparam logic [4:0] KIND_PLUS    = 5'd9;
    localparam logic [4:0] KIND_SLASH   = 5'd10;
    localparam logic [4:0] KIND_STAR    = 5'd11;
    localparam logic [4:0] KIND_INT     = 5'd12;
    localparam logic [4:0] KIND_RETURN  = 5'd13;
    localparam logic [4:0] KIND_IDENT   = 5'd14;
    localparam logic [4:0] KIND_INTEGER = 5'd15;
    localparam logic [4:0] KIND_END     = 5'd16;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [7:0]  length;
    } token_t;

    // Tokens produced by one source byte
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } step_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h0d || c == 8'h0a || c == 8'h09;
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h7b:   k = KIND_LBRACE;
            8'h7d:   k = KIND_RBRACE;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h3b:   k = KIND_SEMI;
            8'h2d:   k = KIND_MINUS;
            8'h7e:   k = KIND_TILDE;
            8'h21:   k = KIND_BANG;
            8'h2b:   k = KIND_PLUS;
            8'h2f:   k = KIND_SLASH;
            8'h2a:   k = KIND_STAR;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // Characters of "int"
    function automatic logic [7:0] kw_int_at(input logic [2:0] i);
        logic [7:0] ch;
        case (i)
            3'd0:    ch = 8'h69;
            3'd1:    ch = 8'h6e;
            3'd2:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Characters of "return"
    function automatic logic [7:0] kw_ret_at(input logic [2:0] i);
        logic [7:0] ch;
        case (i)
            3'd0:    ch = 8'h72;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h75;
            3'd4:    ch = 8'h72;
            3'd5:    ch = 8'h6e;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[src/c_subset_lexer.sv]
// Streaming lexer for a small C subset.
// One source byte per beat enters on s_*; each byte yields zero, one or two token
// beats on m_*. m_tlast marks the final token caused by a byte.
// A byte is held in an input register, classified combinationally against the scanner
// state and its tokens land in a two-slot result register.
// A token is presented from the result register once the byte that closes it has
// passed the input register; a full result register holds that byte back.
// Throughput: one byte per cycle while m_tready is high and each byte gives at most
// one token; a byte giving two tokens (a run closed by a punctuator, other symbol or
// end of stream) holds the next byte until its second token is taken.
// Identifier and number tokens are emitted when the byte that ends them arrives.
// Byte 0x00 or 0xFF emits the end token and restarts the byte offset at zero.
// Reset clears the scanner to idle at offset zero and empties both registers.
// When m_tready is low the tokens hold; one more byte is taken into the input
// register, then s_tready drops until the result register drains.
// Depends on cslx_pkg, cslx_scan and cslx_obuf.
`default_nettype none

module c_subset_lexer
    import cslx_pkg::*;
#(
    parameter int POSITION_BITS    = POSITION_BITS_DEF,
    parameter int MAX_TOKEN_LENGTH = MAX_TOKEN_LENGTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] char_in
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [4:0] token_kind, [20:5] token_start,
                                               // [28:21] token_length, [31:29] zero
    output logic                    m_tlast    // last
);

    logic  load_ok;
    logic  fire;
    step_t step;

    cslx_scan #(
        .POSITION_BITS    (POSITION_BITS),
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .load_ok  (load_ok),
        .fire     (fire),
        .step     (step)
    );

    cslx_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .step     (step),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[src/cslx_scan.sv]
// Input register and scanner: classifies one byte and forms up to two tokens.
// Depends on cslx_pkg and c_subset_lexer_assert.svh.
`default_nettype none

`include "c_subset_lexer_assert.svh"

module cslx_scan
    import cslx_pkg::*;
#(
    parameter int POSITION_BITS    = POSITION_BITS_DEF,
    parameter int MAX_TOKEN_LENGTH = MAX_TOKEN_LENGTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_in
    input  wire logic        load_ok,
    output logic             fire,
    output step_t            step
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LENGTH);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
    localparam logic [LEN_W-1:0] LEN_INT = LEN_W'(3);
    localparam logic [LEN_W-1:0] LEN_RET = LEN_W'(6);

    logic                     in_vld_reg, in_vld_next;
    logic [7:0]               char_reg;
    logic [1:0]               mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [1:0]               flags_reg, flags_next;

    logic       eos;
    logic       flush_v;
    token_t     flush_tok;
    logic       own_v;
    token_t     own_tok;
    logic [LEN_W-1:0] len_inc;
    logic [1:0] flags_ext;

    assign fire     = in_vld_reg && load_ok;
    assign s_tready = !in_vld_reg || fire;

    always_comb
    begin
        if (s_tvalid && s_tready)
        begin
            in_vld_next = 1'b1;
        end
        else if (fire)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end
    end

    // Token for the open run, if any
    always_comb
    begin
        flush_tok.start  = 16'(start_reg);
        flush_tok.length = 8'(len_reg);
        unique case (mode_reg)
            MODE_IDENT:
            begin
                flush_v = 1'b1;
                if (flags_reg[0] && len_reg == LEN_INT)
                begin
                    flush_tok.kind = KIND_INT;
                end
                else if (flags_reg[1] && len_reg == LEN_RET)
                begin
                    flush_tok.kind = KIND_RETURN;
                end
                else
                begin
                    flush_tok.kind = KIND_IDENT;
                end
            end
            MODE_NUMBER:
            begin
                flush_v        = 1'b1;
                flush_tok.kind = KIND_INTEGER;
            end
            default:
            begin
                flush_v        = 1'b0;
                flush_tok.kind = KIND_UNKNOWN;
            end
        endcase
    end

    always_comb
    begin
        eos     = char_reg == 8'h00 || char_reg == 8'hff;
        len_inc = (len_reg < LEN_MAX) ? len_reg + LEN_ONE : len_reg;
        flags_ext[0] = flags_reg[0] && len_reg < LEN_INT
                       && kw_int_at(len_reg[2:0]) == char_reg;
        flags_ext[1] = flags_reg[1] && len_reg < LEN_RET
                       && kw_ret_at(len_reg[2:0]) == char_reg;

        own_tok.start  = 16'(pos_reg);
        own_tok.length = 8'd1;
        own_tok.kind   = punct_kind(char_reg);
        own_v          = 1'b0;

        mode_next  = mode_reg;
        pos_next   = pos_reg + POSITION_BITS'(1);
        start_next = start_reg;
        len_next   = len_reg;
        flags_next = flags_reg;

        if (eos)
        begin
            own_v        = 1'b1;
            own_tok.kind = KIND_END;
            mode_next    = MODE_IDLE;
            pos_next     = '0;
            start_next   = '0;
            len_next     = '0;
            flags_next   = '0;
        end
        else if (mode_reg == MODE_IDENT
                 && (is_letter(char_reg) || is_digit(char_reg) || char_reg == 8'h5f))
        begin
            len_next   = len_inc;
            flags_next = flags_ext;
        end
        else if (mode_reg == MODE_NUMBER && is_digit(char_reg))
        begin
            len_next   = len_inc;
            flags_next = flags_ext;
        end
        else if (is_letter(char_reg))
        begin
            mode_next  = MODE_IDENT;
            start_next = pos_reg;
            len_next   = LEN_ONE;
            flags_next = {char_reg == 8'h72, char_reg == 8'h69};
        end
        else if (is_digit(char_reg))
        begin
            mode_next  = MODE_NUMBER;
            start_next = pos_reg;
            len_next   = LEN_ONE;
            flags_next = '0;
        end
        else
        begin
            // whitespace is dropped, anything else is a one-byte token
            own_v      = !is_space(char_reg);
            mode_next  = MODE_IDLE;
            len_next   = '0;
            flags_next = '0;
        end
    end

    // A run is closed by every byte that does not extend it
    always_comb
    begin
        logic do_flush;
        do_flush = flush_v && (eos || mode_next != mode_reg || len_next == LEN_ONE)
                   && !(mode_next == mode_reg && len_next != LEN_ONE && !eos);
        step.tok0  = do_flush ? flush_tok : own_tok;
        step.tok1  = own_tok;
        step.count = 2'(do_flush) + 2'(own_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            flags_reg  <= '0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (fire)
            begin
                mode_reg  <= mode_next;
                pos_reg   <= pos_next;
                start_reg <= start_next;
                len_reg   <= len_next;
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg <= s_tdata;
        end
    end

    `CSLX_ASSERT_NEXT(a_eos_restart, clk, rst_n, fire && eos, pos_reg == '0 && mode_reg == MODE_IDLE)
    `CSLX_ASSERT_IMPL(a_idle_len, clk, rst_n, mode_reg == MODE_IDLE, len_reg == '0)

endmodule

`default_nettype wire

[src/cslx_obuf.sv]
// Two-slot result register: holds the tokens of one byte and hands them out one a beat.
// Depends on cslx_pkg and c_subset_lexer_assert.svh.
`default_nettype none

`include "c_subset_lexer_assert.svh"

module cslx_obuf
    import cslx_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire step_t              step,
    output logic                    load_ok,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,  // [4:0] token_kind, [20:5] token_start,
                                              // [28:21] token_length, [31:29] zero
    output logic                    m_tlast   // last
);

    logic [1:0] cnt_reg, cnt_next;
    token_t     slot0_reg, slot1_reg;
    logic       take;

    assign m_tvalid = cnt_reg != 2'd0;
    assign take     = m_tvalid && m_tready;
    assign load_ok  = cnt_reg == 2'd0 || (cnt_reg == 2'd1 && m_tready);
    // the final token of a byte is the one left alone in the buffer
    assign m_tlast  = cnt_reg == 2'd1;
    assign m_tdata  = {3'b000, slot0_reg.length, slot0_reg.start, slot0_reg.kind};

    always_comb
    begin
        if (fire)
        begin
            cnt_next = step.count;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            slot0_reg <= step.tok0;
            slot1_reg <= step.tok1;
        end
        else if (take && cnt_reg == 2'd2)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    `CSLX_ASSERT_IMPL(a_no_overwrite, clk, rst_n, fire, cnt_reg == 2'd0 || (cnt_reg == 2'd1 && take))
    `CSLX_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3)
    `CSLX_ASSERT_NEXT(a_pair_load, clk, rst_n, fire && step.count == 2'd2, cnt_reg == 2'd2 && !m_tlast)

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for c_subset_lexer: drives source bytes on s_*, predicts tokens
// with an internal lexer model and compares every m_* beat against it.
// Depends on cslx_pkg and the c_subset_lexer RTL.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cslx_pkg::*;

    localparam int STALL_LIMIT = 200;

    typedef struct {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [7:0]  length;
        logic        last;
    } lex_token_t;

    // Lexer model plus the queue of tokens still owed by the block
    class token_predictor;
        logic [1:0]  scan_mode;
        logic [15:0] offset;
        logic [15:0] run_start;
        logic [7:0]  run_len;
        logic [1:0]  kw_flags;
        lex_token_t  step_tokens[$];
        lex_token_t  expected_tokens[$];
        int          mismatch_count;
        string       kw_int;
        string       kw_ret;

        function new();
            scan_mode = MODE_IDLE;
            offset = '0;
            run_start = '0;
            run_len = '0;
            kw_flags = '0;
            mismatch_count = 0;
            kw_int = "int";
            kw_ret = "return";
        endfunction

        function bit alpha_char(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit digit_char(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit blank_char(logic [7:0] c);
            return c == " " || c == 8'h0d || c == 8'h0a || c == 8'h09;
        endfunction

        function logic [4:0] punct_code(logic [7:0] c);
            case (c)
                "{":     return KIND_LBRACE;
                "}":     return KIND_RBRACE;
                "(":     return KIND_LPAREN;
                ")":     return KIND_RPAREN;
                ";":     return KIND_SEMI;
                "-":     return KIND_MINUS;
                "~":     return KIND_TILDE;
                "!":     return KIND_BANG;
                "+":     return KIND_PLUS;
                "/":     return KIND_SLASH;
                "*":     return KIND_STAR;
                default: return KIND_UNKNOWN;
            endcase
        endfunction

        function void emit(logic [4:0] kind, logic [15:0] start, logic [7:0] length);
            lex_token_t t;
            t.kind = kind;
            t.start = start;
            t.length = length;
            t.last = 1'b0;
            step_tokens.push_back(t);
        endfunction

        // Report the open run, if any, and go idle
        function void close_run();
            logic [4:0] kind;
            if (scan_mode == MODE_IDENT || scan_mode == MODE_NUMBER) begin
                kind = KIND_INTEGER;
                if (scan_mode == MODE_IDENT) begin
                    kind = KIND_IDENT;
                    if (kw_flags[0] && run_len == 8'd3)
                        kind = KIND_INT;
                    else if (kw_flags[1] && run_len == 8'd6)
                        kind = KIND_RETURN;
                end
                emit(kind, run_start, run_len);
                run_len = '0;
                kw_flags = '0;
            end
            scan_mode = MODE_IDLE;
        endfunction

        function void open_run(logic [1:0] mode, logic [7:0] c);
            scan_mode = mode;
            run_start = offset;
            run_len = 8'd1;
            kw_flags = '0;
            if (mode == MODE_IDENT) begin
                kw_flags[0] = (c == "i");
                kw_flags[1] = (c == "r");
            end
        endfunction

        function void grow_run(logic [7:0] c);
            logic [1:0] nf;
            nf = '0;
            if (kw_flags[0] && run_len < 3 && kw_int[run_len] == c)
                nf[0] = 1'b1;
            if (kw_flags[1] && run_len < 6 && kw_ret[run_len] == c)
                nf[1] = 1'b1;
            kw_flags = nf;
            if (run_len < MAX_TOKEN_LENGTH_DEF)
                run_len = run_len + 8'd1;
        endfunction

        function void take_byte(logic [7:0] c);
            bit stream_end;
            stream_end = 1'b0;
            step_tokens.delete();
            if (c == 8'h00 || c == 8'hff) begin
                close_run();
                emit(KIND_END, offset, 8'd1);
                stream_end = 1'b1;
            end else if (scan_mode == MODE_IDENT
                         && (alpha_char(c) || digit_char(c) || c == "_")) begin
                grow_run(c);
            end else if (scan_mode == MODE_NUMBER && digit_char(c)) begin
                grow_run(c);
            end else begin
                close_run();
                if (alpha_char(c))
                    open_run(MODE_IDENT, c);
                else if (digit_char(c))
                    open_run(MODE_NUMBER, c);
                else if (!blank_char(c))
                    emit(punct_code(c), offset, 8'd1);
            end
            if (step_tokens.size() > 0)
                step_tokens[step_tokens.size()-1].last = 1'b1;
            foreach (step_tokens[i])
                expected_tokens.push_back(step_tokens[i]);
            if (stream_end) begin
                offset = '0;
                run_start = '0;
            end else begin
                offset = offset + 16'd1;
            end
        endfunction

        function void check_token(logic [4:0] kind, logic [15:0] start,
                                  logic [7:0] length, logic last);
            lex_token_t e;
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token kind %0d start %0d length %0d last %0d",
                         $time, kind, start, length, last);
                mismatch_count++;
                return;
            end
            e = expected_tokens.pop_front();
            if (kind !== e.kind) begin
                $display("%0t: token_kind expected %0d actual %0d", $time, e.kind, kind);
                mismatch_count++;
            end
            if (start !== e.start) begin
                $display("%0t: token_start expected %0d actual %0d", $time, e.start, start);
                mismatch_count++;
            end
            if (length !== e.length) begin
                $display("%0t: token_length expected %0d actual %0d",
                         $time, e.length, length);
                mismatch_count++;
            end
            if (last !== e.last) begin
                $display("%0t: last expected %0d actual %0d", $time, e.last, last);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = 8'h00;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;

    token_predictor tok_pred = new();
    bit             tx_steady = 1'b0;
    bit             rx_steady = 1'b0;
    int             rx_hold = 0;
    int             quiet_cycles = 0;
    int             sent_bytes = 0;

    c_subset_lexer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Token sink: check each beat, then, unless rx_steady is set, hold off for a random pause
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                tok_pred.check_token(m_tdata[4:0], m_tdata[20:5], m_tdata[28:21], m_tlast);
                rx_hold = rx_steady ? 0 : $urandom_range(0, 5);
            end
            if (rx_hold != 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        do
            @(posedge clk);
        while (!s_tready);
        tok_pred.take_byte(c);
        sent_bytes++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_byte(s[i]);
    endtask

    // Hold the source until every owed token has come out
    task automatic drain_tokens();
        s_tvalid <= 1'b0;
        while (tok_pred.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_alpha();
        int n;
        n = $urandom_range(0, 51);
        return (n < 26) ? 8'("a" + n) : 8'("A" + n - 26);
    endfunction

    function automatic logic [7:0] rand_ident_tail();
        int n;
        n = $urandom_range(0, 62);
        if (n < 52)
            return (n < 26) ? 8'("a" + n) : 8'("A" + n - 26);
        else if (n < 62)
            return 8'("0" + n - 52);
        return "_";
    endfunction

    // One random piece of C-like source
    task automatic send_snippet();
        string kw_pool[9];
        string puncts;
        string blanks;
        int    len;
        kw_pool = '{"int", "return", "in", "intx", "retur", "returns", "ret_1", "i", "r"};
        puncts = "{}();-~!+/*";
        blanks = " \t\r\n";
        case ($urandom_range(0, 19))
            0, 1:
                send_text(kw_pool[$urandom_range(0, 8)]);
            2, 3, 4, 5:
            begin
                send_byte(rand_alpha());
                len = $urandom_range(0, 7);
                repeat (len) send_byte(rand_ident_tail());
            end
            6, 7, 8:
            begin
                len = $urandom_range(1, 5);
                repeat (len) send_byte(8'("0" + $urandom_range(0, 9)));
            end
            9, 10, 11, 12, 13:
                send_byte(puncts[$urandom_range(0, 10)]);
            14, 15:
            begin
                len = $urandom_range(1, 3);
                repeat (len) send_byte(blanks[$urandom_range(0, 3)]);
            end
            16, 17:
                send_byte(8'($urandom_range(0, 255)));
            18:
                if ($urandom_range(0, 3) == 0)
                    send_byte($urandom_range(0, 1) ? 8'hff : 8'h00);
                else
                    send_byte("_");
            default:
                send_byte(" ");
        endcase
        if ($urandom_range(0, 1) == 0)
            send_byte(" ");
    endtask

    initial
    begin
        string long_run;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every punctuator, keywords, run closed by a punctuator,
        // letter after digits, underscore inside an identifier, both end-of-stream bytes
        send_text("{}()-~!+/*;");
        send_text("int return(");
        send_text("1a_");
        send_byte(8'hff);
        send_text("x9\t=");
        send_byte(8'h00);
        drain_tokens();

        // Saturated runs, one starting as a keyword
        tx_steady = 1'b1;
        long_run = "return";
        repeat (254) long_run = {long_run, "q"};
        send_text(long_run);
        send_byte(" ");
        repeat (258) send_byte(8'("0" + $urandom_range(0, 9)));
        send_byte(";");
        send_byte(8'h00);
        drain_tokens();
        tx_steady = 1'b0;

        while (sent_bytes < 850) begin
            send_snippet();
            if ($urandom_range(0, 29) == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 149) == 0)
                drain_tokens();
        end

        s_tvalid <= 1'b0;
        while (tok_pred.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tok_pred.mismatch_count == 0 && tok_pred.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[c_subset_lexer.f]
+incdir+src
src/cslx_pkg.sv
src/cslx_scan.sv
src/cslx_obuf.sv
src/c_subset_lexer.sv
verif/tb_top.sv
